// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LIPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define LIPF_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: rtl/lipf_pkg.sv
// Types and constants of the lidar isolated point filter.
`default_nettype none
package lipf_pkg;

  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [CFG_W-1:0] LOW_RESET   = 16'd0;
  localparam logic [CFG_W-1:0] HIGH_RESET  = 16'd30000;
  localparam logic [CFG_W-1:0] CLOSE_RESET = 16'd0;
  localparam logic [CFG_W-1:0] GAP_RESET   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 4'd0,
    REG_RANGE_HIGH = 4'd1,
    REG_TOO_CLOSE  = 4'd2,
    REG_NBR_GAP    = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] range_low;
    logic [CFG_W-1:0] range_high;
    logic [CFG_W-1:0] too_close;
    logic [CFG_W-1:0] nbr_gap;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [FIELD_W-1:0] mm;
    logic               nan;
    logic               done;
  } out_beat_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } fifo_push_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

endpackage
`default_nettype wire

// File: rtl/lipf_cell.sv
// One sample slot of the window: value, NaN flag and a present flag.
`default_nettype none
module lipf_cell #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire lipf_pkg::cell_ctl_t    ctl_i,
  input  wire logic [SAMPLE_BITS-1:0] value_i,
  input  wire logic                   nan_i,
  output logic [SAMPLE_BITS-1:0]      value_o,
  output logic                        nan_o,
  output logic                        present_o
);

  logic [SAMPLE_BITS-1:0] value_q;
  logic                   nan_q;
  logic                   present_q, present_d;

  always_comb begin
    present_d = present_q;
    if (ctl_i.clear) begin
      present_d = 1'b0;
    end else if (ctl_i.load) begin
      present_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else begin
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      value_q <= value_i;
      nan_q   <= nan_i;
    end
  end

  assign value_o   = value_q;
  assign nan_o     = nan_q;
  assign present_o = present_q;

endmodule
`default_nettype wire

// File: rtl/lipf_decide.sv
// Keep-or-reject decision for one sample given its two neighbors.
`default_nettype none
module lipf_decide #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire lipf_pkg::cfg_t         cfg_i,
  input  wire logic [SAMPLE_BITS-1:0] cur_i,
  input  wire logic                   cur_nan_i,
  input  wire logic                   has_p_i,
  input  wire logic [SAMPLE_BITS-1:0] p_i,
  input  wire logic                   p_nan_i,
  input  wire logic                   has_n_i,
  input  wire logic [SAMPLE_BITS-1:0] n_i,
  input  wire logic                   n_nan_i,
  output logic [SAMPLE_BITS-1:0]      res_o,
  output logic                        res_nan_o
);

  // compare width: covers both the sample and the 16 bit limits plus one
  localparam int unsigned CW =
    ((SAMPLE_BITS > lipf_pkg::CFG_W) ? SAMPLE_BITS : lipf_pkg::CFG_W) + 1;

  logic [CW-1:0] cur, p, n, lo, hi, tc, gap, mark_raw, mask, mark;
  logic [CW-1:0] dp, dn;
  logic          oor, close, pv, nv, pfar, nfar, rej;

  always_comb begin
    cur      = CW'(cur_i);
    p        = CW'(p_i);
    n        = CW'(n_i);
    lo       = CW'(cfg_i.range_low);
    hi       = CW'(cfg_i.range_high);
    tc       = CW'(cfg_i.too_close);
    gap      = CW'(cfg_i.nbr_gap);
    mask     = CW'({SAMPLE_BITS{1'b1}});
    mark_raw = hi + CW'(1);
    mark     = (mark_raw > mask) ? mask : mark_raw;

    dp = (p > cur) ? (p - cur) : (cur - p);
    dn = (n > cur) ? (n - cur) : (cur - n);

    oor   = !cur_nan_i && ((cur > hi) || (cur < lo));
    close = !cur_nan_i && (cur < tc);
    pv    = has_p_i && !p_nan_i && (p > lo) && (p < hi);
    nv    = has_n_i && !n_nan_i && (n > lo) && (n < hi);
    pfar  = !has_p_i || (!p_nan_i && !cur_nan_i && (dp > gap));
    nfar  = !has_n_i || (!n_nan_i && !cur_nan_i && (dn > gap));
    rej   = !oor && (close || (!pv && !nv) || (pfar && nfar));

    res_o     = rej ? mark[SAMPLE_BITS-1:0] : cur_i;
    res_nan_o = rej ? 1'b0 : cur_nan_i;
  end

endmodule
`default_nettype wire

// File: rtl/lipf_ofifo.sv
// Small output queue, up to two pushes and one pop per cycle; head at entry 0.
`default_nettype none
module lipf_ofifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lipf_pkg::fifo_push_t push_i,
  input  wire lipf_pkg::out_beat_t  beat_a_i,
  input  wire lipf_pkg::out_beat_t  beat_b_i,
  input  wire logic                 pop_i,
  output lipf_pkg::out_beat_t       head_o,
  output lipf_pkg::fifo_stat_t      stat_o
);

  localparam int unsigned D  = lipf_pkg::FIFO_DEPTH;
  localparam int unsigned CW = lipf_pkg::FIFO_CNT_W;

  lipf_pkg::out_beat_t entry_q [D];
  lipf_pkg::out_beat_t entry_d [D];
  lipf_pkg::out_beat_t first_beat;
  logic [CW-1:0]       count_q, count_d, base, n_push;

  always_comb begin
    // compact: a lone second push goes to the first free slot
    first_beat = push_i.push_a ? beat_a_i : beat_b_i;
    n_push     = CW'(push_i.push_a) + CW'(push_i.push_b);
    base       = count_q - CW'(pop_i);
    count_d    = base + n_push;
    for (int i = 0; i < D; i++) begin
      if (pop_i && (i < D - 1)) begin
        entry_d[i] = entry_q[i+1];
      end else begin
        entry_d[i] = entry_q[i];
      end
      if ((n_push != '0) && (CW'(i) == base)) begin
        entry_d[i] = first_beat;
      end
      if ((n_push == CW'(2)) && (CW'(i) == base + CW'(1))) begin
        entry_d[i] = beat_b_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  assign head_o       = entry_q[0];
  assign stat_o.count = count_q;

endmodule
`default_nettype wire

// File: rtl/lidar_isolated_point_filter.sv
// Top level of the lidar isolated point filter: window cells, decisions, output queue.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_stall_o   range_mm_i, not_a_number_i, end_of_scan_i
//   out      out  out_valid_o / out_stall_i filtered_mm_o, filtered_nan_o, scan_done_o
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One input beat per cycle. A beat's result is pushed when the next beat is
// taken and leaves the queue the next cycle at the earliest; an end-of-scan
// beat also pushes its own result, so it pushes two unless it opens its scan.
// The four-entry output queue sets the rate: in_stall_o is high while fewer
// than two slots are free. Reset empties the window and the queue and loads
// the register defaults. Output stalls back up through the queue only.
`default_nettype none
`include "assert_macros.svh"
module lidar_isolated_point_filter #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [lipf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lipf_pkg::CFG_W-1:0]      cfg_data_i,
  // input samples
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [lipf_pkg::FIELD_W-1:0]    range_mm_i,
  input  wire logic                            not_a_number_i,
  input  wire logic                            end_of_scan_i,
  // filtered samples
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [lipf_pkg::FIELD_W-1:0]         filtered_mm_o,
  output logic                                 filtered_nan_o,
  output logic                                 scan_done_o
);

  localparam int unsigned SW = SAMPLE_BITS;
  // wide enough for the sample, the 16 bit port and one spare bit
  localparam int unsigned XW =
    ((SAMPLE_BITS > lipf_pkg::FIELD_W) ? SAMPLE_BITS : lipf_pkg::FIELD_W) + 1;

  // ---------------- configuration registers ----------------
  lipf_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (lipf_pkg::cfg_reg_e'(cfg_idx_i))
        lipf_pkg::REG_RANGE_LOW:  cfg_d.range_low  = cfg_data_i;
        lipf_pkg::REG_RANGE_HIGH: cfg_d.range_high = cfg_data_i;
        lipf_pkg::REG_TOO_CLOSE:  cfg_d.too_close  = cfg_data_i;
        lipf_pkg::REG_NBR_GAP:    cfg_d.nbr_gap    = cfg_data_i;
        default:                  cfg_d = cfg_q;  // unused index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_low  <= lipf_pkg::LOW_RESET;
      cfg_q.range_high <= lipf_pkg::HIGH_RESET;
      cfg_q.too_close  <= lipf_pkg::CLOSE_RESET;
      cfg_q.nbr_gap    <= lipf_pkg::GAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- input beat ----------------
  logic              in_acc, last;
  logic [XW-1:0]     raw_ext;
  logic [SW-1:0]     r;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign last    = end_of_scan_i;
  assign raw_ext = XW'(range_mm_i);
  // NaN samples carry a zero range from here on
  assign r       = not_a_number_i ? '0 : raw_ext[SW-1:0];

  // ---------------- window cells ----------------
  // held: sample waiting for its next neighbor (raw).
  // prev: filtered sample before held; its present flag says held is not
  // the first of its scan.
  lipf_pkg::cell_ctl_t held_ctl, prev_ctl;
  logic [SW-1:0]       held_v, prev_v, res_a, res_b;
  logic                held_nan, held_pres, prev_nan, prev_pres, res_a_nan, res_b_nan;

  assign held_ctl.load  = in_acc && !last;
  assign held_ctl.clear = in_acc && last;
  assign prev_ctl.load  = in_acc && !last && held_pres;
  assign prev_ctl.clear = in_acc && last;

  lipf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_held (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (held_ctl),
    .value_i   (r),
    .nan_i     (not_a_number_i),
    .value_o   (held_v),
    .nan_o     (held_nan),
    .present_o (held_pres)
  );

  lipf_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_prev (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (prev_ctl),
    .value_i   (res_a),
    .nan_i     (res_a_nan),
    .value_o   (prev_v),
    .nan_o     (prev_nan),
    .present_o (prev_pres)
  );

  // held sample, judged against filtered prev and the raw incoming sample
  lipf_decide #(.SAMPLE_BITS(SAMPLE_BITS)) u_dec_held (
    .cfg_i     (cfg_q),
    .cur_i     (held_v),
    .cur_nan_i (held_nan),
    .has_p_i   (prev_pres),
    .p_i       (prev_v),
    .p_nan_i   (prev_nan),
    .has_n_i   (1'b1),
    .n_i       (r),
    .n_nan_i   (not_a_number_i),
    .res_o     (res_a),
    .res_nan_o (res_a_nan)
  );

  // last sample of a scan: previous neighbor is the held result, no next
  lipf_decide #(.SAMPLE_BITS(SAMPLE_BITS)) u_dec_last (
    .cfg_i     (cfg_q),
    .cur_i     (r),
    .cur_nan_i (not_a_number_i),
    .has_p_i   (held_pres),
    .p_i       (res_a),
    .p_nan_i   (res_a_nan),
    .has_n_i   (1'b0),
    .n_i       ('0),
    .n_nan_i   (1'b0),
    .res_o     (res_b),
    .res_nan_o (res_b_nan)
  );

  // ---------------- output queue ----------------
  lipf_pkg::fifo_push_t push;
  lipf_pkg::out_beat_t  beat_a, beat_b, head;
  lipf_pkg::fifo_stat_t fstat;
  logic [XW-1:0]        res_a_ext, res_b_ext;
  logic                 pop;

  assign res_a_ext = XW'(res_a);
  assign res_b_ext = XW'(res_b);

  assign push.push_a = in_acc && held_pres;
  assign push.push_b = in_acc && last;

  assign beat_a.mm   = res_a_nan ? '0 : res_a_ext[lipf_pkg::FIELD_W-1:0];
  assign beat_a.nan  = res_a_nan;
  assign beat_a.done = 1'b0;
  assign beat_b.mm   = res_b_nan ? '0 : res_b_ext[lipf_pkg::FIELD_W-1:0];
  assign beat_b.nan  = res_b_nan;
  assign beat_b.done = 1'b1;

  assign pop = out_valid_o && !out_stall_i;

  lipf_ofifo u_ofifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .beat_a_i (beat_a),
    .beat_b_i (beat_b),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (fstat)
  );

  // room for two pushes required before taking a beat
  assign in_stall_o = fstat.count >
    lipf_pkg::FIFO_CNT_W'(lipf_pkg::FIFO_DEPTH - 2);
  assign out_valid_o    = fstat.count != '0;
  assign filtered_mm_o  = head.mm;
  assign filtered_nan_o = head.nan;
  assign scan_done_o    = head.done;

  // ---------------- assertions ----------------
  `LIPF_ASSERT_NEVER(a_fifo_bound,
    fstat.count > lipf_pkg::FIFO_CNT_W'(lipf_pkg::FIFO_DEPTH), "output queue overflow")
  `LIPF_ASSERT_NEVER(a_prev_needs_held, prev_pres && !held_pres,
    "prev cell present without a held sample")
  `LIPF_ASSERT(a_scan_end_flush, in_acc && last |=> !held_pres && !prev_pres,
    "window not emptied after end of scan")
  `LIPF_ASSERT(a_prev_follows, in_acc && !last && held_pres |=> prev_pres,
    "filtered neighbor not kept")

endmodule
`default_nettype wire
